// ===== sv/ecbu_pkg.sv =====
// shared types, constants and helper functions of the camera basis update block
package ecbu_pkg;

    // angle units are 1/65536 degree
    localparam logic [24:0] FULL_TURN    = 25'd23592960;
    localparam logic [22:0] QUARTER_TURN = 23'd5898240;
    localparam logic [21:0] EIGHTH_TURN  = 22'd2949120;
    localparam logic [22:0] LIMIT_MAX    = 23'd5898239;

    // reset values
    localparam logic [24:0] YAW_RESET    = 25'd17694720;
    localparam logic [15:0] SENS_RESET   = 16'd6554;
    localparam logic [22:0] LIMIT_RESET  = 23'd5832704;

    // degree to q30 radian scale, split into a 9-bit high part and a 32-bit low part
    localparam logic [8:0]  RAD_HI       = 9'd285;
    localparam logic [31:0] RAD_LO       = 32'd4100597034;
    localparam logic [30:0] Q30_ONE      = 31'h4000_0000;

    // yaw reduction: 360 * 128 offset and floor(2^24 / 360)
    localparam logic [16:0] WRAP_OFFSET  = 17'd46080;
    localparam logic [15:0] WRAP_RECIP   = 16'd46603;
    localparam logic [8:0]  DEG_FULL     = 9'd360;

    // configuration register indexes
    localparam logic CFG_SENS  = 1'b0;
    localparam logic CFG_LIMIT = 1'b1;

    // angle pair handed from front to back
    typedef struct packed {
        logic [24:0]        yaw;
        logic signed [23:0] pitch;
    } t_ang;

    // sequencer states of the trig engine
    typedef enum logic [3:0] {
        B_IDLE, B_LOAD, B_XLO, B_XHI, B_SQ, B_SQR, B_HMUL, B_HREC, B_HFIX,
        B_SMUL, B_SEND, B_PASS, B_PMUL, B_PGET, B_DONE
    } t_bstate;

    // taylor divisors of the horner steps
    function automatic logic [7:0] f_div(input logic cosm, input logic [2:0] idx);
        logic [7:0] d;
        d = 8'd2;
        if (!cosm) begin
            case (idx)
                3'd0: d = 8'd110;
                3'd1: d = 8'd72;
                3'd2: d = 8'd42;
                3'd3: d = 8'd20;
                default: d = 8'd6;
            endcase
        end else begin
            case (idx)
                3'd0: d = 8'd132;
                3'd1: d = 8'd90;
                3'd2: d = 8'd56;
                3'd3: d = 8'd30;
                3'd4: d = 8'd12;
                default: d = 8'd2;
            endcase
        end
        return d;
    endfunction

    // floor(2^32 / divisor)
    function automatic logic [31:0] f_recip(input logic cosm, input logic [2:0] idx);
        logic [31:0] m;
        m = 32'd2147483648;
        if (!cosm) begin
            case (idx)
                3'd0: m = 32'd39045157;
                3'd1: m = 32'd59652323;
                3'd2: m = 32'd102261126;
                3'd3: m = 32'd214748364;
                default: m = 32'd715827882;
            endcase
        end else begin
            case (idx)
                3'd0: m = 32'd32537631;
                3'd1: m = 32'd47721858;
                3'd2: m = 32'd76695844;
                3'd3: m = 32'd143165576;
                3'd4: m = 32'd357913941;
                default: m = 32'd2147483648;
            endcase
        end
        return m;
    endfunction

    // q30 magnitude with sign to q1.14, half away from zero
    function automatic logic signed [15:0] f_q14(input logic neg, input logic [30:0] m);
        logic [31:0] s;
        logic [15:0] r;
        s = {1'b0, m} + 32'd32768;
        r = {1'b0, s[30:16]};
        return neg ? -$signed(r) : $signed(r);
    endfunction

endpackage

// ===== sv/ecbu_front.sv =====
// front end: takes pointer words and updates yaw and pitch
module ecbu_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic signed [15:0] i_x_offset,
    input  logic signed [15:0] i_y_offset,
    input  logic              i_cfg_we,
    input  logic              i_cfg_addr,
    input  logic [22:0]       i_cfg_data,
    input  logic              i_q_full,
    output logic              o_q_push,
    output ecbu_pkg::t_ang    o_q_data
);

    logic [15:0]        r_sens;
    logic [22:0]        r_limit;
    logic [24:0]        r_yaw;
    logic signed [23:0] r_pitch;
    logic               r_a_vld;
    logic signed [32:0] r_xs;
    logic signed [32:0] r_ys;

    logic               b_fire;
    logic signed [33:0] vy;
    logic signed [33:0] vp;
    logic signed [18:0] hp;
    logic [32:0]        qprod;
    logic [7:0]         q;
    logic [16:0]        rem;
    logic [8:0]         remf;
    logic [22:0]        lim;
    logic signed [33:0] slim;
    logic [24:0]        n_yaw;
    logic signed [23:0] n_pitch;

    assign b_fire  = r_a_vld && !i_q_full;
    assign o_ready = !r_a_vld || b_fire;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sens  <= ecbu_pkg::SENS_RESET;
            r_limit <= ecbu_pkg::LIMIT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                ecbu_pkg::CFG_SENS:  r_sens  <= i_cfg_data[15:0];
                ecbu_pkg::CFG_LIMIT: r_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // stage a: scale the offsets by the sensitivity
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (o_ready) begin
            r_a_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_xs <= i_x_offset * $signed({1'b0, r_sens});
            r_ys <= i_y_offset * $signed({1'b0, r_sens});
        end
    end

    // stage b: yaw wrap through 360 on the upper bits, pitch clamp
    always_comb begin
        vy    = $signed({9'd0, r_yaw}) + 34'(r_xs);
        hp    = 19'(vy[33:16]) + $signed({2'b0, ecbu_pkg::WRAP_OFFSET});
        qprod = hp[16:0] * ecbu_pkg::WRAP_RECIP;
        q     = qprod[31:24];
        rem   = hp[16:0] - 17'(q * ecbu_pkg::DEG_FULL);
        remf  = (rem >= 17'(ecbu_pkg::DEG_FULL)) ? 9'(rem - 17'(ecbu_pkg::DEG_FULL))
                                                 : rem[8:0];
        n_yaw = {remf, vy[15:0]};

        lim   = (r_limit > ecbu_pkg::LIMIT_MAX) ? ecbu_pkg::LIMIT_MAX : r_limit;
        slim  = $signed({11'd0, lim});
        vp    = 34'(r_pitch) - 34'(r_ys);
        if (vp > slim) begin
            n_pitch = 24'(slim);
        end else if (vp < -slim) begin
            n_pitch = 24'(-slim);
        end else begin
            n_pitch = 24'(vp);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_yaw   <= ecbu_pkg::YAW_RESET;
            r_pitch <= '0;
        end else if (b_fire) begin
            r_yaw   <= n_yaw;
            r_pitch <= n_pitch;
        end
    end

    assign o_q_push       = b_fire;
    assign o_q_data.yaw   = n_yaw;
    assign o_q_data.pitch = n_pitch;

    // kept angles stay in range
    a_yaw_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_yaw < ecbu_pkg::FULL_TURN)
        else $error("yaw out of range");

    a_pitch_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pitch <= $signed({1'b0, ecbu_pkg::LIMIT_MAX}))
        && (r_pitch >= -$signed({1'b0, ecbu_pkg::LIMIT_MAX})))
        else $error("pitch out of range");

endmodule

// ===== sv/ecbu_fifo.sv =====
// short angle queue between front end and trig engine
module ecbu_fifo #(
    parameter int DEPTH = 2
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  ecbu_pkg::t_ang i_data,
    output logic           o_full,
    input  logic           i_pop,
    output ecbu_pkg::t_ang o_data,
    output logic           o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    ecbu_pkg::t_ang r_mem [DEPTH];
    logic [AW-1:0]  r_wp;
    logic [AW-1:0]  r_rp;
    logic [CW-1:0]  r_cnt;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty))
        else $error("pop from empty queue");

endmodule

// ===== sv/ecbu_back.sv =====
// trig engine: horner series on one shared multiplier, then the basis vectors
module ecbu_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_empty,
    input  ecbu_pkg::t_ang i_q_data,
    output logic           o_q_pop,
    output logic           o_m_tvalid,
    input  logic           i_m_tready,
    output logic [183:0]   o_m_tdata
);

    ecbu_pkg::t_bstate r_state, n_state;

    logic [24:0]        r_yaw;
    logic signed [23:0] r_pitch;
    logic               r_pass;
    logic               r_swap;
    logic [1:0]         r_quad;
    logic [21:0]        r_a;
    logic [29:0]        r_x;
    logic [30:0]        r_x2;
    logic [30:0]        r_t;
    logic [30:0]        r_p;
    logic [30:0]        r_s;
    logic [2:0]         r_i;
    logic               r_cosm;
    logic [1:0]         r_k;
    logic [63:0]        r_prod;
    logic [30:0]        r_sy, r_cy, r_sp, r_cp;
    logic               r_syn, r_cyn, r_spn;
    logic signed [15:0] r_res [4];
    logic               r_out_vld;
    logic [183:0]       r_out;

    logic [31:0]        mul_a, mul_b;
    logic [24:0]        ang;
    logic [22:0]        pmag;
    logic [1:0]         quad;
    logic [22:0]        rred;
    logic [30:0]        p_cur;
    logic [30:0]        q0;
    logic [7:0]         dv;
    logic [38:0]        rem;
    logic [30:0]        q_fix;
    logic [30:0]        s0, c0;
    logic               last_step;
    logic               out_free;
    logic [30:0]        pm_a, pm_b;
    logic               pneg;

    assign out_free = !r_out_vld || i_m_tready;

    // angle reduction to a quadrant and a residue
    always_comb begin
        pmag = r_pitch[23] ? 23'(-r_pitch) : r_pitch[22:0];
        ang  = r_pass ? {2'b0, pmag} : r_yaw;
        if (ang < 25'(ecbu_pkg::QUARTER_TURN)) begin
            quad = 2'd0;
        end else if (ang < 25'({ecbu_pkg::QUARTER_TURN, 1'b0})) begin
            quad = 2'd1;
        end else if (ang < 25'(3 * ecbu_pkg::QUARTER_TURN)) begin
            quad = 2'd2;
        end else begin
            quad = 2'd3;
        end
        rred = 23'(ang - 25'(quad * ecbu_pkg::QUARTER_TURN));
    end

    // horner step pieces and division fix-up
    always_comb begin
        p_cur     = r_prod[60:30];
        dv        = ecbu_pkg::f_div(r_cosm, r_i);
        q0        = r_prod[62:32];
        rem       = {8'd0, r_p} - 39'(q0 * dv);
        q_fix     = (rem >= 39'(dv)) ? q0 + 1'b1 : q0;
        last_step = r_cosm ? (r_i == 3'd5) : (r_i == 3'd4);
        s0        = r_swap ? r_t : r_s;
        c0        = r_swap ? r_s : r_t;
    end

    // operand pairs of the final products
    always_comb begin
        case (r_k)
            2'd0: begin pm_a = r_cy; pm_b = r_cp; pneg = r_cyn; end
            2'd1: begin pm_a = r_sy; pm_b = r_cp; pneg = r_syn; end
            2'd2: begin pm_a = r_cy; pm_b = r_sp; pneg = !r_cyn ^ r_spn; end
            default: begin pm_a = r_sy; pm_b = r_sp; pneg = !r_syn ^ r_spn; end
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ecbu_pkg::B_IDLE: if (!i_q_empty) n_state = ecbu_pkg::B_LOAD;
            ecbu_pkg::B_LOAD: n_state = ecbu_pkg::B_XLO;
            ecbu_pkg::B_XLO:  n_state = ecbu_pkg::B_XHI;
            ecbu_pkg::B_XHI:  n_state = ecbu_pkg::B_SQ;
            ecbu_pkg::B_SQ:   n_state = ecbu_pkg::B_SQR;
            ecbu_pkg::B_SQR:  n_state = ecbu_pkg::B_HMUL;
            ecbu_pkg::B_HMUL: n_state = ecbu_pkg::B_HREC;
            ecbu_pkg::B_HREC: n_state = ecbu_pkg::B_HFIX;
            ecbu_pkg::B_HFIX: begin
                if (!last_step) begin
                    n_state = ecbu_pkg::B_HMUL;
                end else if (r_cosm) begin
                    n_state = ecbu_pkg::B_PASS;
                end else begin
                    n_state = ecbu_pkg::B_SMUL;
                end
            end
            ecbu_pkg::B_SMUL: n_state = ecbu_pkg::B_SEND;
            ecbu_pkg::B_SEND: n_state = ecbu_pkg::B_HMUL;
            ecbu_pkg::B_PASS: n_state = r_pass ? ecbu_pkg::B_PMUL : ecbu_pkg::B_LOAD;
            ecbu_pkg::B_PMUL: n_state = ecbu_pkg::B_PGET;
            ecbu_pkg::B_PGET: n_state = (r_k == 2'd3) ? ecbu_pkg::B_DONE : ecbu_pkg::B_PMUL;
            ecbu_pkg::B_DONE: if (out_free) n_state = ecbu_pkg::B_IDLE;
            default:          n_state = ecbu_pkg::B_IDLE;
        endcase
    end

    // outputs of the sequencer: multiplier operands and queue pop
    always_comb begin
        mul_a   = '0;
        mul_b   = '0;
        o_q_pop = 1'b0;
        case (r_state)
            ecbu_pkg::B_IDLE: o_q_pop = !i_q_empty;
            ecbu_pkg::B_XLO:  begin mul_a = 32'(r_a);  mul_b = ecbu_pkg::RAD_LO; end
            ecbu_pkg::B_SQ:   begin mul_a = 32'(r_x);  mul_b = 32'(r_x); end
            ecbu_pkg::B_HMUL: begin mul_a = 32'(r_x2); mul_b = 32'(r_t); end
            ecbu_pkg::B_HREC: begin
                mul_a = 32'(p_cur);
                mul_b = ecbu_pkg::f_recip(r_cosm, r_i);
            end
            ecbu_pkg::B_SMUL: begin mul_a = 32'(r_x);  mul_b = 32'(r_t); end
            ecbu_pkg::B_PMUL: begin mul_a = 32'(pm_a); mul_b = 32'(pm_b); end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ecbu_pkg::B_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // shared multiplier
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            ecbu_pkg::B_IDLE: begin
                r_yaw   <= i_q_data.yaw;
                r_pitch <= i_q_data.pitch;
                r_pass  <= 1'b0;
            end
            ecbu_pkg::B_LOAD: begin
                r_quad <= quad;
                if (rred <= 23'(ecbu_pkg::EIGHTH_TURN)) begin
                    r_a    <= rred[21:0];
                    r_swap <= 1'b0;
                end else begin
                    r_a    <= 22'(ecbu_pkg::QUARTER_TURN - rred);
                    r_swap <= 1'b1;
                end
            end
            ecbu_pkg::B_XHI: r_x <= 30'(r_prod[63:32] + 32'(r_a * ecbu_pkg::RAD_HI));
            ecbu_pkg::B_SQR: begin
                r_x2   <= r_prod[60:30];
                r_t    <= ecbu_pkg::Q30_ONE;
                r_i    <= '0;
                r_cosm <= 1'b0;
            end
            ecbu_pkg::B_HREC: r_p <= p_cur;
            ecbu_pkg::B_HFIX: begin
                r_t <= ecbu_pkg::Q30_ONE - q_fix;
                r_i <= r_i + 1'b1;
            end
            ecbu_pkg::B_SEND: begin
                r_s    <= r_prod[60:30];
                r_t    <= ecbu_pkg::Q30_ONE;
                r_i    <= '0;
                r_cosm <= 1'b1;
            end
            ecbu_pkg::B_PASS: begin
                r_pass <= 1'b1;
                r_k    <= '0;
                if (!r_pass) begin
                    // quadrant symmetry of yaw
                    case (r_quad)
                        2'd0: begin
                            r_sy <= s0; r_syn <= 1'b0; r_cy <= c0; r_cyn <= 1'b0;
                        end
                        2'd1: begin
                            r_sy <= c0; r_syn <= 1'b0; r_cy <= s0; r_cyn <= 1'b1;
                        end
                        2'd2: begin
                            r_sy <= s0; r_syn <= 1'b1; r_cy <= c0; r_cyn <= 1'b1;
                        end
                        default: begin
                            r_sy <= c0; r_syn <= 1'b1; r_cy <= s0; r_cyn <= 1'b0;
                        end
                    endcase
                end else begin
                    r_sp  <= s0;
                    r_spn <= r_pitch[23];
                    r_cp  <= c0;
                end
            end
            ecbu_pkg::B_PGET: begin
                r_res[r_k] <= ecbu_pkg::f_q14(pneg, r_prod[60:30]);
                r_k        <= r_k + 1'b1;
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (r_state == ecbu_pkg::B_DONE && out_free) begin
            r_out_vld <= 1'b1;
        end else if (i_m_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ecbu_pkg::B_DONE && out_free) begin
            r_out <= {7'd0, r_pitch, r_yaw,
                      r_res[3],
                      ecbu_pkg::f_q14(1'b0, r_cp),
                      r_res[2],
                      ecbu_pkg::f_q14(r_cyn, r_cy),
                      ecbu_pkg::f_q14(!r_syn, r_sy),
                      r_res[1],
                      ecbu_pkg::f_q14(r_spn, r_sp),
                      r_res[0]};
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_out;

endmodule

// ===== sv/euler_camera_basis_update.sv =====
// top level of the yaw and pitch camera basis update block
//
//  channel   dir  handshake                  payload
//  s         in   i_s_tvalid / o_s_tready    i_s_tdata: x_offset, y_offset
//  m         out  o_m_tvalid / i_m_tready    o_m_tdata: basis vectors, yaw, pitch
//  cfg       in   i_cfg_we                   i_cfg_addr, i_cfg_data
//
//  the front end scales a word at the edge that takes it and pushes the new
//  angles from stage b when the queue is not full; it can run ahead of the trig
//  engine by the queue depth; the trig engine works a word as one pop, two passes
//  (yaw, pitch) with eleven divide steps each on one shared 32x32 multiplier,
//  four products and a hand-off, and pops no new word before that hand-off
//  synchronous active-low reset; no clearing pass
//  a stalled output holds the result while the engine starts the next word
module euler_camera_basis_update #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // x_offset[15:0], y_offset[31:16]
    input  logic [31:0]  i_s_tdata,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // front_x, front_y, front_z, right_x, right_z, up_x, up_y, up_z (16 each),
    // yaw_out[152:128], pitch_out[176:153], zero pad
    output logic [183:0] o_m_tdata,
    input  logic         i_cfg_we,
    input  logic         i_cfg_addr,
    input  logic [22:0]  i_cfg_data
);

    logic           q_push, q_pop, q_full, q_empty;
    ecbu_pkg::t_ang q_in, q_out;

    // angle update
    ecbu_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_s_tvalid),
        .o_ready    (o_s_tready),
        .i_x_offset (i_s_tdata[15:0]),
        .i_y_offset (i_s_tdata[31:16]),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .i_q_full   (q_full),
        .o_q_push   (q_push),
        .o_q_data   (q_in)
    );

    // angle queue
    ecbu_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_out),
        .o_empty (q_empty)
    );

    // trig engine
    ecbu_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_empty  (q_empty),
        .i_q_data   (q_out),
        .o_q_pop    (q_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

endmodule

// ===== test/euler_camera_basis_update_test.sv =====
// self-checking testbench of the yaw and pitch camera basis update block
`timescale 1ns / 1ps

module euler_camera_basis_update_test;

    // expected word, laid out as o_m_tdata[176:0]
    typedef struct packed {
        logic signed [23:0] pitch;
        logic [24:0]        yaw;
        logic signed [15:0] up_z, up_y, up_x, right_z, right_x, front_z, front_y, front_x;
    } t_pose;

    typedef struct {
        logic signed [15:0] x_off;
        logic signed [15:0] y_off;
        bit                 typed;
        t_pose              pose;
    } t_move_row;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_s_tvalid = 1'b0;
    logic         o_s_tready;
    logic [31:0]  i_s_tdata = '0;
    logic         o_m_tvalid;
    logic         i_m_tready = 1'b0;
    logic [183:0] o_m_tdata;
    logic         i_cfg_we = 1'b0;
    logic         i_cfg_addr = ecbu_pkg::CFG_SENS;
    logic [22:0]  i_cfg_data = '0;

    euler_camera_basis_update dut (.*);

    // clock, period 8 ns
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // predictor state and register copies
    longint         yaw_st, pitch_st;
    longint         sens_reg, limit_reg;
    t_pose          pose_q[$];
    int             mismatches = 0;
    int             hold_cycles = 0;

    localparam longint unsigned RAD_SCALE_Q = 64'd1228166276394;
    localparam longint unsigned ONE_Q30 = 64'd1 << 30;

    // sin and cos over [0, 45] degrees, unsigned q30
    function automatic void trig_octant(input longint unsigned a,
                                        output longint unsigned s, output longint unsigned c);
        longint unsigned sd[5] = '{110, 72, 42, 20, 6};
        longint unsigned cd[6] = '{132, 90, 56, 30, 12, 2};
        longint unsigned x, x2, t;
        x = (a * RAD_SCALE_Q) >> 32;
        x2 = (x * x) >> 30;
        t = ONE_Q30;
        for (int i = 0; i < 5; i++) t = ONE_Q30 - ((x2 * t) >> 30) / sd[i];
        s = (x * t) >> 30;
        t = ONE_Q30;
        for (int i = 0; i < 6; i++) t = ONE_Q30 - ((x2 * t) >> 30) / cd[i];
        c = t;
    endfunction

    // sin and cos over [0, 90] degrees
    function automatic void trig_quadrant(input longint unsigned r,
                                          output longint unsigned s, output longint unsigned c);
        if (r <= 64'd2949120) trig_octant(r, s, c);
        else trig_octant(64'd5898240 - r, c, s);
    endfunction

    function automatic longint abs_q(input longint v);
        return v < 0 ? -v : v;
    endfunction

    // q30 to q1.14, half away from zero
    function automatic logic signed [15:0] q30_to_q14(input longint v);
        longint m;
        m = (abs_q(v) + 32768) >>> 16;
        return v < 0 ? 16'(-m) : 16'(m);
    endfunction

    function automatic logic signed [15:0] q30_mul_q14(input longint a, input longint b);
        longint p;
        p = longint'((unsigned'(abs_q(a)) * unsigned'(abs_q(b))) >> 30);
        return ((a < 0) != (b < 0)) ? q30_to_q14(-p) : q30_to_q14(p);
    endfunction

    // apply one pointer move to the camera angles and return the new basis
    function automatic t_pose camera_move(input logic signed [15:0] dx,
                                          input logic signed [15:0] dy);
        longint lim, v, sy, cy, sp, cp;
        longint unsigned s0, c0, r, q, ps, pc;
        t_pose p;
        lim = limit_reg > 5898239 ? 5898239 : limit_reg;
        v = (yaw_st + longint'(dx) * sens_reg) % 23592960;
        if (v < 0) v += 23592960;
        yaw_st = v;
        v = pitch_st - longint'(dy) * sens_reg;
        if (v > lim) v = lim;
        if (v < -lim) v = -lim;
        pitch_st = v;
        q = (yaw_st / 5898240) & 3;
        r = yaw_st % 5898240;
        trig_quadrant(r, s0, c0);
        case (q)
            0: begin sy = s0;  cy = c0;  end
            1: begin sy = c0;  cy = -longint'(s0); end
            2: begin sy = -longint'(s0); cy = -longint'(c0); end
            default: begin sy = -longint'(c0); cy = s0; end
        endcase
        trig_quadrant(abs_q(pitch_st), ps, pc);
        sp = pitch_st < 0 ? -longint'(ps) : longint'(ps);
        cp = pc;
        p.front_x = q30_mul_q14(cy, cp);
        p.front_y = q30_to_q14(sp);
        p.front_z = q30_mul_q14(sy, cp);
        p.right_x = q30_to_q14(-sy);
        p.right_z = q30_to_q14(cy);
        p.up_x    = q30_mul_q14(-cy, sp);
        p.up_y    = q30_to_q14(cp);
        p.up_z    = q30_mul_q14(-sy, sp);
        p.yaw     = 25'(yaw_st);
        p.pitch   = 24'(pitch_st);
        return p;
    endfunction

    // register write, only while idle
    task automatic write_reg(input logic addr, input logic [22:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (addr == ecbu_pkg::CFG_SENS) sens_reg = val[15:0];
        else limit_reg = val;
    endtask

    // stop offering and wait until every word has come out
    task automatic drain;
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (pose_q.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    // offer one word, gap after it at random
    int burst_left = 0;
    task automatic send_move(input logic signed [15:0] dx, input logic signed [15:0] dy,
                             input bit typed, input t_pose typed_pose);
        t_pose p;
        @(negedge i_clk);
        i_s_tvalid <= 1'b1;
        i_s_tdata <= {dy, dx};
        do @(posedge i_clk); while (!o_s_tready);
        p = camera_move(dx, dy);
        pose_q.push_back(typed ? typed_pose : p);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 12);
            @(negedge i_clk);
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(0, 9)) @(negedge i_clk);
        end
    endtask

    function automatic logic signed [15:0] rand_offset();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 2) return 16'($urandom);
        if (r < 8) return 16'($urandom_range(0, 400) - 200);
        if (r == 8) return r[0] ? 16'sh7fff : 16'sh8000;
        return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
    endfunction

    // receiver stall pattern, with a long hold on request
    initial begin
        int mode, cnt;
        mode = 0;
        cnt = 0;
        forever begin
            @(negedge i_clk);
            if (cnt == 0) begin
                mode = $urandom_range(0, 2);
                cnt = $urandom_range(16, 96);
            end
            cnt--;
            if (hold_cycles > 0) begin
                hold_cycles--;
                i_m_tready <= 1'b0;
            end else case (mode)
                0: i_m_tready <= 1'b1;
                1: i_m_tready <= ($urandom_range(0, 3) != 0);
                default: i_m_tready <= cnt[0];
            endcase
        end
    end

    // output check at the rising edge
    initial begin
        t_pose exp_p, got_p;
        longint ev[10], gv[10];
        string fname[10] = '{"front_x", "front_y", "front_z", "right_x", "right_z",
                             "up_x", "up_y", "up_z", "yaw_out", "pitch_out"};
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_tvalid && i_m_tready) begin
                got_p = t_pose'(o_m_tdata[176:0]);
                if (pose_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected word %h", o_m_tdata);
                end else begin
                    exp_p = pose_q.pop_front();
                    ev = '{exp_p.front_x, exp_p.front_y, exp_p.front_z, exp_p.right_x,
                           exp_p.right_z, exp_p.up_x, exp_p.up_y, exp_p.up_z,
                           exp_p.yaw, exp_p.pitch};
                    gv = '{got_p.front_x, got_p.front_y, got_p.front_z, got_p.right_x,
                           got_p.right_z, got_p.up_x, got_p.up_y, got_p.up_z,
                           got_p.yaw, got_p.pitch};
                    for (int i = 0; i < 10; i++) begin
                        if (ev[i] != gv[i]) begin
                            mismatches++;
                            if (mismatches <= 10)
                                $display("%s mismatch: expected %0d got %0d",
                                         fname[i], ev[i], gv[i]);
                        end
                    end
                end
            end
        end
    end

    // run limit
    initial begin
        #6ms;
        $display("== FAIL ==");
        $finish;
    end

    // stimulus
    initial begin
        t_move_row dir_tbl[$];
        t_move_row row;
        t_pose home;
        logic [15:0] sens_set[6] = '{16'd65535, 16'd0, 16'd1, 16'd3, 16'd0, 16'd0};
        logic [22:0] lim_set[6] = '{23'h7fffff, 23'd0, ecbu_pkg::LIMIT_MAX, 23'd2949120,
                                    23'd0, 23'd0};

        sens_reg = ecbu_pkg::SENS_RESET;
        limit_reg = ecbu_pkg::LIMIT_RESET;
        yaw_st = ecbu_pkg::YAW_RESET;
        pitch_st = 0;

        home = '{pitch: 24'sd0, yaw: ecbu_pkg::YAW_RESET, up_z: 16'sd0, up_y: 16'sd16384,
                 up_x: 16'sd0, right_z: 16'sd0, right_x: 16'sd16384,
                 front_z: -16'sd16384, front_y: 16'sd0, front_x: 16'sd0};
        // straight ahead after reset, then field extremes, unit steps, mid-size moves and bit patterns
        dir_tbl.push_back('{16'sd0, 16'sd0, 1'b1, home});
        dir_tbl.push_back('{16'sh7fff, 16'sd0, 1'b0, '0});
        dir_tbl.push_back('{16'sh8000, 16'sd0, 1'b0, '0});
        dir_tbl.push_back('{16'sd0, 16'sh8000, 1'b0, '0});
        dir_tbl.push_back('{16'sd0, 16'sh7fff, 1'b0, '0});
        dir_tbl.push_back('{-16'sd1, -16'sd1, 1'b0, '0});
        dir_tbl.push_back('{16'sd1, 16'sd1, 1'b0, '0});
        dir_tbl.push_back('{16'sd900, -16'sd300, 1'b0, '0});
        dir_tbl.push_back('{16'sd900, 16'sd600, 1'b0, '0});
        dir_tbl.push_back('{16'sd900, -16'sd10, 1'b0, '0});
        dir_tbl.push_back('{16'sh5555, 16'shaaaa, 1'b0, '0});
        dir_tbl.push_back('{16'shaaaa, 16'sh5555, 1'b0, '0});

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_tbl[i]) begin
            row = dir_tbl[i];
            send_move(row.x_off, row.y_off, row.typed, row.pose);
        end

        // oversized limit and largest sensitivity, wraps on both sides
        drain();
        write_reg(ecbu_pkg::CFG_SENS, 23'd65535);
        write_reg(ecbu_pkg::CFG_LIMIT, 23'h7fffff);
        send_move(16'sh7fff, 16'sh8000, 1'b0, '0);
        send_move(16'sh8000, 16'sh7fff, 1'b0, '0);
        send_move(16'sd1, -16'sd1, 1'b0, '0);
        // lowered limit takes hold on the next move
        drain();
        write_reg(ecbu_pkg::CFG_LIMIT, 23'd65536);
        send_move(16'sd0, 16'sd0, 1'b0, '0);
        drain();
        write_reg(ecbu_pkg::CFG_SENS, 23'd0);
        write_reg(ecbu_pkg::CFG_LIMIT, 23'd0);
        send_move(16'sd12345, -16'sd12345, 1'b0, '0);

        // random phases over several register settings
        for (int ph = 0; ph < 6; ph++) begin
            drain();
            write_reg(ecbu_pkg::CFG_SENS,
                      ph < 4 ? sens_set[ph] : 23'($urandom_range(1, 3000)));
            write_reg(ecbu_pkg::CFG_LIMIT, ph < 4 ? lim_set[ph] : 23'($urandom));
            for (int n = 0; n < 270; n++) begin
                if (ph == 2 && n == 40) hold_cycles = 400;
                send_move(rand_offset(), rand_offset(), 1'b0, '0);
            end
        end

        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (pose_q.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
